@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// No dependencies; include once through the guard below.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/nolt_pkg.sv @@
// Package of the named object LRU table: field widths, status codes,
// controller states and the command and token flag structs. No dependencies.
package nolt_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int NAME_BYTES_DEF = 8;

    localparam int STATUS_W = 3;
    localparam int TYPE_W   = 4;
    localparam int NAME_W   = 64;
    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 4;
    localparam int STAMP_W  = 64;

    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXIST  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INSERT = 3'd4;

    localparam logic MODE_FIND     = 1'b0;
    localparam logic MODE_REGISTER = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

    // Write command broadcast to the cells.
    typedef struct packed {
        logic write;   // refresh the stamp of the addressed cell
        logic insert;  // also load key and handle and mark the cell valid
    } t_cmd;

    // Control part of the search token that walks the cell chain.
    typedef struct packed {
        logic valid;   // token present at this stage
        logic hit;     // a matching entry was seen
        logic empty;   // an empty entry was seen
    } t_tok_flags;

endpackage

@@ rtl/nolt_cell.sv @@
// One table entry of the named object LRU table plus one stage of the
// search token chain. Depends on nolt_pkg.
module nolt_cell #(
    parameter int IDX_W   = 4,
    parameter int SLOT_ID = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [nolt_pkg::TYPE_W-1:0]   i_q_type,
    input  logic [nolt_pkg::NAME_W-1:0]   i_q_name,
    input  logic [nolt_pkg::HANDLE_W-1:0] i_q_handle,
    input  nolt_pkg::t_cmd                i_cmd,
    input  logic [IDX_W-1:0]              i_cmd_idx,
    input  logic [nolt_pkg::STAMP_W-1:0]  i_cmd_stamp,
    input  nolt_pkg::t_tok_flags          i_flags,
    input  logic [IDX_W-1:0]              i_hit_idx,
    input  logic [nolt_pkg::HANDLE_W-1:0] i_hit_handle,
    input  logic [IDX_W-1:0]              i_empty_idx,
    input  logic [nolt_pkg::STAMP_W-1:0]  i_best_stamp,
    input  logic [IDX_W-1:0]              i_best_idx,
    input  logic [nolt_pkg::HANDLE_W-1:0] i_best_handle,
    output nolt_pkg::t_tok_flags          o_flags,
    output logic [IDX_W-1:0]              o_hit_idx,
    output logic [nolt_pkg::HANDLE_W-1:0] o_hit_handle,
    output logic [IDX_W-1:0]              o_empty_idx,
    output logic [nolt_pkg::STAMP_W-1:0]  o_best_stamp,
    output logic [IDX_W-1:0]              o_best_idx,
    output logic [nolt_pkg::HANDLE_W-1:0] o_best_handle
);

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(SLOT_ID);
    localparam logic             IS_FIRST = (SLOT_ID == 0);

    // Entry contents.
    logic                          r_valid;
    logic [nolt_pkg::TYPE_W-1:0]   r_type;
    logic [nolt_pkg::NAME_W-1:0]   r_name;
    logic [nolt_pkg::HANDLE_W-1:0] r_handle;
    logic [nolt_pkg::STAMP_W-1:0]  r_stamp;

    // Token stage.
    nolt_pkg::t_tok_flags          r_flags, n_flags;
    logic [IDX_W-1:0]              r_hit_idx, n_hit_idx;
    logic [nolt_pkg::HANDLE_W-1:0] r_hit_handle, n_hit_handle;
    logic [IDX_W-1:0]              r_empty_idx, n_empty_idx;
    logic [nolt_pkg::STAMP_W-1:0]  r_best_stamp, n_best_stamp;
    logic [IDX_W-1:0]              r_best_idx, n_best_idx;
    logic [nolt_pkg::HANDLE_W-1:0] r_best_handle, n_best_handle;

    logic match;
    logic sel;

    assign match = r_valid && (r_type == i_q_type) && (r_name == i_q_name);
    assign sel   = i_cmd.write && (i_cmd_idx == MY_IDX);

    always_comb begin
        n_flags       = i_flags;
        n_hit_idx     = i_hit_idx;
        n_hit_handle  = i_hit_handle;
        n_empty_idx   = i_empty_idx;
        n_best_stamp  = i_best_stamp;
        n_best_idx    = i_best_idx;
        n_best_handle = i_best_handle;
        if (!i_flags.hit && match) begin
            n_flags.hit  = 1'b1;
            n_hit_idx    = MY_IDX;
            n_hit_handle = r_handle;
        end
        if (!i_flags.empty && !r_valid) begin
            n_flags.empty = 1'b1;
            n_empty_idx   = MY_IDX;
        end
        // A valid first cell always seeds the oldest-entry search with itself.
        if (r_valid && (IS_FIRST || (r_stamp < i_best_stamp))) begin
            n_best_stamp  = r_stamp;
            n_best_idx    = MY_IDX;
            n_best_handle = r_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
            if (sel && i_cmd.insert) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx     <= n_hit_idx;
        r_hit_handle  <= n_hit_handle;
        r_empty_idx   <= n_empty_idx;
        r_best_stamp  <= n_best_stamp;
        r_best_idx    <= n_best_idx;
        r_best_handle <= n_best_handle;
        if (sel) begin
            r_stamp <= i_cmd_stamp;
            if (i_cmd.insert) begin
                r_type   <= i_q_type;
                r_name   <= i_q_name;
                r_handle <= i_q_handle;
            end
        end
    end

    assign o_flags       = r_flags;
    assign o_hit_idx     = r_hit_idx;
    assign o_hit_handle  = r_hit_handle;
    assign o_empty_idx   = r_empty_idx;
    assign o_best_stamp  = r_best_stamp;
    assign o_best_idx    = r_best_idx;
    assign o_best_handle = r_best_handle;

endmodule

@@ rtl/nolt_ctrl.sv @@
// Controller of the named object LRU table: request intake, name check,
// use counter, decision at the end of the cell chain and result register.
// Depends on nolt_pkg.
module nolt_ctrl #(
    parameter int IDX_W      = 4,
    parameter int NAME_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [nolt_pkg::TYPE_W-1:0]   i_obj_type,
    input  logic [nolt_pkg::NAME_W-1:0]   i_name_key,
    input  logic [nolt_pkg::HANDLE_W-1:0] i_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nolt_pkg::STATUS_W-1:0] o_status,
    output logic [nolt_pkg::HANDLE_W-1:0] o_found_handle,
    output logic [nolt_pkg::HANDLE_W-1:0] o_evicted_handle,
    output logic [nolt_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [nolt_pkg::TYPE_W-1:0]   o_q_type,
    output logic [nolt_pkg::NAME_W-1:0]   o_q_name,
    output logic [nolt_pkg::HANDLE_W-1:0] o_q_handle,
    output logic                          o_inject,
    output nolt_pkg::t_cmd                o_cmd,
    output logic [IDX_W-1:0]              o_cmd_idx,
    output logic [nolt_pkg::STAMP_W-1:0]  o_cmd_stamp,
    input  nolt_pkg::t_tok_flags          i_flags,
    input  logic [IDX_W-1:0]              i_hit_idx,
    input  logic [nolt_pkg::HANDLE_W-1:0] i_hit_handle,
    input  logic [IDX_W-1:0]              i_empty_idx,
    input  logic [IDX_W-1:0]              i_best_idx,
    input  logic [nolt_pkg::HANDLE_W-1:0] i_best_handle
);

    nolt_pkg::t_state              r_state, n_state;
    logic                          r_inject, n_inject;
    nolt_pkg::t_cmd                r_cmd, n_cmd;
    logic [IDX_W-1:0]              r_cmd_idx, n_cmd_idx;
    logic [nolt_pkg::STAMP_W-1:0]  r_counter, n_counter;
    logic                          r_out_valid, n_out_valid;

    logic                          r_mode;
    logic [nolt_pkg::TYPE_W-1:0]   r_q_type;
    logic [nolt_pkg::NAME_W-1:0]   r_q_name;
    logic [nolt_pkg::HANDLE_W-1:0] r_q_handle;

    logic [nolt_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [nolt_pkg::HANDLE_W-1:0] r_res_found, n_res_found;
    logic [nolt_pkg::HANDLE_W-1:0] r_res_evicted, n_res_evicted;
    logic [nolt_pkg::SLOT_W-1:0]   r_res_slot, n_res_slot;

    logic [nolt_pkg::STATUS_W-1:0] r_status;
    logic [nolt_pkg::HANDLE_W-1:0] r_found;
    logic [nolt_pkg::HANDLE_W-1:0] r_evicted;
    logic [nolt_pkg::SLOT_W-1:0]   r_slot;

    logic [nolt_pkg::NAME_W-1:0]   norm_name;
    logic                          name_empty;
    logic                          name_full;
    logic                          reject;
    logic                          accept;
    logic                          load_out;
    logic [nolt_pkg::STAMP_W-1:0]  next_stamp;
    logic [IDX_W-1:0]              dec_idx;

    // Name check: the name ends at the first zero byte; bytes from there on
    // and beyond the examined width are cleared.
    always_comb begin
        logic keep;
        keep      = 1'b1;
        norm_name = '0;
        name_full = 1'b1;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (i_name_key[8*b +: 8] == 8'd0) begin
                keep      = 1'b0;
                name_full = 1'b0;
            end
            if (keep) begin
                norm_name[8*b +: 8] = i_name_key[8*b +: 8];
            end
        end
    end

    assign name_empty = (i_name_key[7:0] == 8'd0);
    assign reject     = name_empty || name_full ||
                        ((i_mode == nolt_pkg::MODE_REGISTER) && (i_handle == '0));
    assign accept     = i_in_valid && o_in_ready;
    assign load_out   = (r_state == nolt_pkg::S_RESULT) && (!r_out_valid || i_out_ready);
    assign next_stamp = r_counter + nolt_pkg::STAMP_W'(1);

    always_comb begin
        n_state       = r_state;
        n_inject      = 1'b0;
        n_cmd         = '0;
        n_cmd_idx     = r_cmd_idx;
        n_counter     = r_counter;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_res_status  = r_res_status;
        n_res_found   = r_res_found;
        n_res_evicted = r_res_evicted;
        n_res_slot    = r_res_slot;
        dec_idx       = i_hit_idx;
        unique case (r_state)
            nolt_pkg::S_IDLE: begin
                if (accept) begin
                    if (reject) begin
                        n_res_status  = nolt_pkg::ST_REJECT;
                        n_res_found   = '0;
                        n_res_evicted = '0;
                        n_res_slot    = '0;
                        n_state       = nolt_pkg::S_RESULT;
                    end else begin
                        n_inject = 1'b1;
                        n_state  = nolt_pkg::S_SEARCH;
                    end
                end
            end
            nolt_pkg::S_SEARCH: begin
                if (i_flags.valid) begin
                    n_res_found   = '0;
                    n_res_evicted = '0;
                    n_res_slot    = '0;
                    if (i_flags.hit) begin
                        dec_idx = i_hit_idx;
                    end else if (i_flags.empty) begin
                        dec_idx = i_empty_idx;
                    end else begin
                        dec_idx = i_best_idx;
                    end
                    if (r_mode == nolt_pkg::MODE_FIND && !i_flags.hit) begin
                        n_res_status = nolt_pkg::ST_MISS;
                    end else begin
                        n_cmd.write = 1'b1;
                        n_cmd_idx   = dec_idx;
                        n_counter   = next_stamp;
                        n_res_slot  = nolt_pkg::SLOT_W'(dec_idx);
                        if (r_mode == nolt_pkg::MODE_FIND) begin
                            n_res_status = nolt_pkg::ST_HIT;
                            n_res_found  = i_hit_handle;
                        end else if (i_flags.hit) begin
                            n_res_status = nolt_pkg::ST_EXIST;
                        end else begin
                            n_cmd.insert = 1'b1;
                            n_res_status = nolt_pkg::ST_INSERT;
                            if (!i_flags.empty) begin
                                n_res_evicted = i_best_handle;
                            end
                        end
                    end
                    n_state = nolt_pkg::S_RESULT;
                end
            end
            nolt_pkg::S_RESULT: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = nolt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nolt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nolt_pkg::S_IDLE;
            r_inject    <= 1'b0;
            r_cmd       <= '0;
            r_counter   <= nolt_pkg::STAMP_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inject    <= n_inject;
            r_cmd       <= n_cmd;
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd_idx     <= n_cmd_idx;
        r_res_status  <= n_res_status;
        r_res_found   <= n_res_found;
        r_res_evicted <= n_res_evicted;
        r_res_slot    <= n_res_slot;
        if (accept) begin
            r_mode     <= i_mode;
            r_q_type   <= i_obj_type;
            r_q_name   <= norm_name;
            r_q_handle <= i_handle;
        end
        if (load_out) begin
            r_status  <= r_res_status;
            r_found   <= r_res_found;
            r_evicted <= r_res_evicted;
            r_slot    <= r_res_slot;
        end
    end

    assign o_in_ready       = (r_state == nolt_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_handle   = r_found;
    assign o_evicted_handle = r_evicted;
    assign o_slot_index     = r_slot;
    assign o_q_type         = r_q_type;
    assign o_q_name         = r_q_name;
    assign o_q_handle       = r_q_handle;
    assign o_inject         = r_inject;
    assign o_cmd            = r_cmd;
    assign o_cmd_idx        = r_cmd_idx;
    assign o_cmd_stamp      = r_counter;

endmodule

@@ rtl/named_object_lru_table_unit.sv @@
// Top level of the named object LRU table: a controller and a chain of
// SLOTS entry cells. Depends on nolt_pkg, nolt_ctrl and nolt_cell.
//
//   Channel   Signals                              Direction   Moves
//   request   i_in_valid / o_in_ready              in          mode, type, name, handle
//   result    o_out_valid / i_out_ready            out         status, handles, slot
//
// A request that passes the name and handle checks becomes a search token
// that steps through one cell per cycle; the controller decides at the end
// of the chain and loads the output register from its result state. A
// rejected request goes straight to the result state. Reset is synchronous
// and active low and leaves every entry empty with the use counter at one.
// A stalled result holds the next finished result in the controller until
// the output register frees up; a new request is taken while a result still waits.
module named_object_lru_table_unit #(
    parameter int SLOTS      = nolt_pkg::SLOTS_DEF,
    parameter int NAME_BYTES = nolt_pkg::NAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [nolt_pkg::TYPE_W-1:0]   i_obj_type,
    input  logic [nolt_pkg::NAME_W-1:0]   i_name_key,
    input  logic [nolt_pkg::HANDLE_W-1:0] i_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nolt_pkg::STATUS_W-1:0] o_status,
    output logic [nolt_pkg::HANDLE_W-1:0] o_found_handle,
    output logic [nolt_pkg::HANDLE_W-1:0] o_evicted_handle,
    output logic [nolt_pkg::SLOT_W-1:0]   o_slot_index
);

    // One index bit at least, even for a single-slot table.
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Query and write command, broadcast from the controller to all cells.
    logic [nolt_pkg::TYPE_W-1:0]   q_type;
    logic [nolt_pkg::NAME_W-1:0]   q_name;
    logic [nolt_pkg::HANDLE_W-1:0] q_handle;
    logic                          inject;
    nolt_pkg::t_cmd                cmd;
    logic [IDX_W-1:0]              cmd_idx;
    logic [nolt_pkg::STAMP_W-1:0]  cmd_stamp;

    // Search token at each point of the chain; point 0 is the injected
    // token and point SLOTS is what the last cell hands to the controller.
    nolt_pkg::t_tok_flags          tok_flags       [SLOTS+1];
    logic [IDX_W-1:0]              tok_hit_idx     [SLOTS+1];
    logic [nolt_pkg::HANDLE_W-1:0] tok_hit_handle  [SLOTS+1];
    logic [IDX_W-1:0]              tok_empty_idx   [SLOTS+1];
    logic [nolt_pkg::STAMP_W-1:0]  tok_best_stamp  [SLOTS+1];
    logic [IDX_W-1:0]              tok_best_idx    [SLOTS+1];
    logic [nolt_pkg::HANDLE_W-1:0] tok_best_handle [SLOTS+1];

    // A fresh token has seen nothing; the oldest stamp starts at all ones.
    assign tok_flags[0]        = '{valid: inject, hit: 1'b0, empty: 1'b0};
    assign tok_hit_idx[0]      = '0;
    assign tok_hit_handle[0]   = '0;
    assign tok_empty_idx[0]    = '0;
    assign tok_best_stamp[0]   = '1;
    assign tok_best_idx[0]     = '0;
    assign tok_best_handle[0]  = '0;

    nolt_ctrl #(
        .IDX_W      (IDX_W),
        .NAME_BYTES (NAME_BYTES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_obj_type       (i_obj_type),
        .i_name_key       (i_name_key),
        .i_handle         (i_handle),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found_handle   (o_found_handle),
        .o_evicted_handle (o_evicted_handle),
        .o_slot_index     (o_slot_index),
        .o_q_type         (q_type),
        .o_q_name         (q_name),
        .o_q_handle       (q_handle),
        .o_inject         (inject),
        .o_cmd            (cmd),
        .o_cmd_idx        (cmd_idx),
        .o_cmd_stamp      (cmd_stamp),
        .i_flags          (tok_flags[SLOTS]),
        .i_hit_idx        (tok_hit_idx[SLOTS]),
        .i_hit_handle     (tok_hit_handle[SLOTS]),
        .i_empty_idx      (tok_empty_idx[SLOTS]),
        .i_best_idx       (tok_best_idx[SLOTS]),
        .i_best_handle    (tok_best_handle[SLOTS])
    );

    // The controller only acts on the oldest stamp through the chosen index,
    // so the stamp leaving the last cell is not needed further.
    for (genvar s = 0; s < SLOTS; s++) begin : g_cell
        nolt_cell #(
            .IDX_W   (IDX_W),
            .SLOT_ID (s)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_q_type      (q_type),
            .i_q_name      (q_name),
            .i_q_handle    (q_handle),
            .i_cmd         (cmd),
            .i_cmd_idx     (cmd_idx),
            .i_cmd_stamp   (cmd_stamp),
            .i_flags       (tok_flags[s]),
            .i_hit_idx     (tok_hit_idx[s]),
            .i_hit_handle  (tok_hit_handle[s]),
            .i_empty_idx   (tok_empty_idx[s]),
            .i_best_stamp  (tok_best_stamp[s]),
            .i_best_idx    (tok_best_idx[s]),
            .i_best_handle (tok_best_handle[s]),
            .o_flags       (tok_flags[s+1]),
            .o_hit_idx     (tok_hit_idx[s+1]),
            .o_hit_handle  (tok_hit_handle[s+1]),
            .o_empty_idx   (tok_empty_idx[s+1]),
            .o_best_stamp  (tok_best_stamp[s+1]),
            .o_best_idx    (tok_best_idx[s+1]),
            .o_best_handle (tok_best_handle[s+1])
        );
    end

endmodule

@@ rtl/nolt_checker.sv @@
// Port-level checker for the named object LRU table, bound to the top level.
// Depends on nolt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nolt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [nolt_pkg::STATUS_W-1:0] o_status,
    input logic [nolt_pkg::HANDLE_W-1:0] o_found_handle,
    input logic [nolt_pkg::HANDLE_W-1:0] o_evicted_handle,
    input logic [nolt_pkg::SLOT_W-1:0]   o_slot_index
);

    `ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_found_handle) && $stable(o_evicted_handle) && $stable(o_slot_index), "stalled result changed")

    `ASSERT_CLK(a_quiet_fields, i_clk, i_rst_n, o_out_valid && (o_status == nolt_pkg::ST_REJECT || o_status == nolt_pkg::ST_MISS) |-> o_found_handle == '0 && o_evicted_handle == '0 && o_slot_index == '0, "rejected or missed result carries data")

    `ASSERT_CLK(a_found_only_hit, i_clk, i_rst_n, o_out_valid && o_found_handle != '0 |-> o_status == nolt_pkg::ST_HIT, "found handle outside a find hit")

    `ASSERT_CLK(a_evict_only_insert, i_clk, i_rst_n, o_out_valid && o_evicted_handle != '0 |-> o_status == nolt_pkg::ST_INSERT, "evicted handle outside an insertion")

endmodule

bind named_object_lru_table_unit nolt_checker u_nolt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_found_handle   (o_found_handle),
    .o_evicted_handle (o_evicted_handle),
    .o_slot_index     (o_slot_index)
);
